// ----- rtl/sem_pkg.sv -----
// ============================================================================
// sem_pkg: shared types and constants of the Sobel edge magnitude block
// Frame limits, register indexes and the controller/datapath interface.
// ============================================================================
package sem_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    // Column/row counters and coordinates
    localparam int COORD_W = $clog2(MAX_WIDTH);
    // Register value width
    localparam int DIM_W = 12;
    localparam int CFG_INDEX_W = 4;
    localparam int PIX_W = 8;
    // |gx|, |gy| reach 4*255
    localparam int ABS_W = 10;
    // gx^2 + gy^2 reaches 2*1020^2
    localparam int SUM_W = 22;
    localparam int ROOT_W = 8;
    localparam int STEP_W = $clog2(ROOT_W);

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

    localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);
    localparam logic [DIM_W-1:0] MIN_DIM      = DIM_W'(3);

    typedef struct packed {
        logic              accept;     // capture pixel, read line stores
        logic              load;       // gradients, store update, advance
        logic              square;     // sum of squares
        logic              root_step;  // one bit of the square root
        logic [STEP_W-1:0] step;       // bit under trial
        logic              publish;    // move result to output register
    } sem_cmd_t;

    typedef struct packed {
        logic emit;       // current pixel completes an interior window
        logic out_free;   // output register can take a result
        logic at_origin;  // counters point at first pixel of a frame
    } sem_status_t;

endpackage

// ----- rtl/sem_ctrl.sv -----
// ============================================================================
// sem_ctrl: sequencer of the Sobel edge magnitude block
// Steps each pixel through read and gradient; an interior one on through square, root and publish.
// ============================================================================
module sem_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sem_pkg::sem_status_t status,
    output sem_pkg::sem_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_SQUARE = 3'd2;
    localparam logic [2:0] S_ROOT   = 3'd3;
    localparam logic [2:0] S_HOLD   = 3'd4;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic [sem_pkg::STEP_W-1:0]  step_reg;
    logic [sem_pkg::STEP_W-1:0]  step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = status.emit ? S_SQUARE : S_IDLE;
            end
            S_SQUARE:
            begin
                cmd.square = 1'b1;
                step_next  = sem_pkg::STEP_W'(sem_pkg::ROOT_W - 1);
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                step_next     = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ----- rtl/sem_datapath.sv -----
// ============================================================================
// sem_datapath: line stores, window, gradient and root of the Sobel block
// Holds configuration, counters and the output register.
// ============================================================================
module sem_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sem_pkg::sem_cmd_t                    cmd,
    output sem_pkg::sem_status_t                 status,
    input  logic                                 cfg_write,
    input  logic [sem_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [sem_pkg::DIM_W-1:0]            cfg_data,
    input  logic [sem_pkg::PIX_W-1:0]            red_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [sem_pkg::COORD_W-1:0]          out_row,
    output logic [sem_pkg::COORD_W-1:0]          out_column,
    output logic [sem_pkg::ROOT_W-1:0]           magnitude,
    output logic                                 last_of_frame
);

    localparam int DEPTH = sem_pkg::MAX_WIDTH;
    localparam int CW    = sem_pkg::COORD_W;
    localparam int DW    = sem_pkg::DIM_W;
    localparam int PW    = sem_pkg::PIX_W;
    localparam int GW    = sem_pkg::ABS_W + 2;

    logic [DW-1:0] width_reg;
    logic [DW-1:0] height_reg;
    logic [DW-1:0] width_eff;
    logic [DW-1:0] height_eff;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] row_reg;

    logic [PW-1:0] older_mem [DEPTH];
    logic [PW-1:0] newer_mem [DEPTH];
    logic [PW-1:0] top_q;
    logic [PW-1:0] mid_q;
    logic [PW-1:0] pix_reg;
    logic [PW-1:0] win_reg [6];

    logic [sem_pkg::ABS_W-1:0]  ax_reg;
    logic [sem_pkg::ABS_W-1:0]  ay_reg;
    logic [sem_pkg::SUM_W-1:0]  sum_reg;
    logic [sem_pkg::ROOT_W-1:0] root_reg;
    logic [CW-1:0]              row_meta_reg;
    logic [CW-1:0]              col_meta_reg;
    logic                       last_meta_reg;

    logic                       out_valid_reg;
    logic [CW-1:0]              out_row_reg;
    logic [CW-1:0]              out_col_reg;
    logic [sem_pkg::ROOT_W-1:0] out_mag_reg;
    logic                       out_last_reg;

    logic          col_wrap;
    logic          row_wrap;
    logic          cfg_hit;
    logic [GW-1:0] pos_x;
    logic [GW-1:0] neg_x;
    logic [GW-1:0] pos_y;
    logic [GW-1:0] neg_y;
    logic [GW-1:0] gx;
    logic [GW-1:0] gy;
    logic [sem_pkg::ROOT_W-1:0]   trial;
    logic [2*sem_pkg::ROOT_W-1:0] trial_sq;
    logic                         sum_sat;

    // Clamp the frame size to the supported range
    always_comb
    begin
        width_eff = width_reg;
        if (width_reg < sem_pkg::MIN_DIM)
        begin
            width_eff = sem_pkg::MIN_DIM;
        end
        else if (width_reg > DW'(sem_pkg::MAX_WIDTH))
        begin
            width_eff = DW'(sem_pkg::MAX_WIDTH);
        end
        height_eff = height_reg;
        if (height_reg < sem_pkg::MIN_DIM)
        begin
            height_eff = sem_pkg::MIN_DIM;
        end
        else if (height_reg > DW'(sem_pkg::MAX_HEIGHT))
        begin
            height_eff = DW'(sem_pkg::MAX_HEIGHT);
        end
    end

    assign cfg_hit  = cfg_write && (cfg_index == sem_pkg::REG_IMAGE_WIDTH
                                 || cfg_index == sem_pkg::REG_IMAGE_HEIGHT);
    assign col_wrap = ({1'b0, col_reg} + DW'(1)) >= width_eff;
    assign row_wrap = ({1'b0, row_reg} + DW'(1)) >= height_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sem_pkg::RESET_WIDTH;
            height_reg <= sem_pkg::RESET_HEIGHT;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            if (cfg_write && cfg_index == sem_pkg::REG_IMAGE_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == sem_pkg::REG_IMAGE_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
            // A write to the width or height register restarts the frame
            if (cfg_hit)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (cmd.load)
            begin
                if (col_wrap)
                begin
                    col_reg <= '0;
                    row_reg <= row_wrap ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    // Line stores: read on accept, write back on load at the same column
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            top_q   <= older_mem[col_reg];
            mid_q   <= newer_mem[col_reg];
            pix_reg <= red_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            older_mem[col_reg] <= mid_q;
            newer_mem[col_reg] <= pix_reg;
        end
    end

    // Window slots: 0..2 column c-2, 3..5 column c-1 (top, middle, bottom)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (cmd.load)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_q;
            win_reg[4] <= mid_q;
            win_reg[5] <= pix_reg;
        end
    end

    always_comb
    begin
        pos_x = GW'(win_reg[2]) + GW'({win_reg[5], 1'b0}) + GW'(pix_reg);
        neg_x = GW'(win_reg[0]) + GW'({win_reg[3], 1'b0}) + GW'(top_q);
        pos_y = GW'(top_q) + GW'({mid_q, 1'b0}) + GW'(pix_reg);
        neg_y = GW'(win_reg[0]) + GW'({win_reg[1], 1'b0}) + GW'(win_reg[2]);
        gx    = pos_x - neg_x;
        gy    = pos_y - neg_y;
    end

    assign sum_sat  = sum_reg >= sem_pkg::SUM_W'(65536);
    assign trial    = root_reg | (sem_pkg::ROOT_W'(1) << cmd.step);
    assign trial_sq = trial * trial;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg        <= gx[GW-1] ? sem_pkg::ABS_W'(-gx) : sem_pkg::ABS_W'(gx);
            ay_reg        <= gy[GW-1] ? sem_pkg::ABS_W'(-gy) : sem_pkg::ABS_W'(gy);
            row_meta_reg  <= row_reg - 1'b1;
            col_meta_reg  <= col_reg - 1'b1;
            last_meta_reg <= ({1'b0, row_reg} == height_eff - DW'(1))
                          && ({1'b0, col_reg} == width_eff - DW'(1));
        end
        if (cmd.square)
        begin
            sum_reg  <= sem_pkg::SUM_W'(ax_reg * ax_reg)
                      + sem_pkg::SUM_W'(ay_reg * ay_reg);
            root_reg <= '0;
        end
        // Keep the trial bit when its square still fits
        if (cmd.root_step && (sem_pkg::SUM_W'(trial_sq) <= sum_reg))
        begin
            root_reg <= trial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_row_reg  <= row_meta_reg;
            out_col_reg  <= col_meta_reg;
            out_mag_reg  <= sum_sat ? '1 : root_reg;
            out_last_reg <= last_meta_reg;
        end
    end

    assign status.emit      = (row_reg >= CW'(2)) && (col_reg >= CW'(2));
    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.at_origin = (row_reg == '0) && (col_reg == '0);

    assign out_valid     = out_valid_reg;
    assign out_row       = out_row_reg;
    assign out_column    = out_col_reg;
    assign magnitude     = out_mag_reg;
    assign last_of_frame = out_last_reg;

endmodule

// ----- rtl/sobel_edge_magnitude.sv -----
// ============================================================================
// sobel_edge_magnitude: streaming 3x3 Sobel gradient magnitude
// Raster-order pixels in, interior-pixel coordinates and magnitude out.
// ============================================================================
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------
//  in      | in_valid / in_ready   | red_value[7:0]
//  out     | out_valid / out_ready | out_row, out_column, magnitude,
//          |                       | last_of_frame
//  cfg     | cfg_valid / cfg_ready | cfg_index (0 width, 1 height), cfg_data
//
//  A border pixel takes accept and line store update; an interior pixel
//  adds sum of squares, 8 steps of the bit-serial square root, publish.
//  The square root iteration sets the rate; in_ready stays low until done.
//  The output register lets the next pixel enter while a result waits.
//  Reset clears counters and the window; line stores need no clearing.
//  cfg_ready is always high; a write to width or height restarts the frame.
//
module sobel_edge_magnitude (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [sem_pkg::PIX_W-1:0]            red_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [sem_pkg::COORD_W-1:0]          out_row,
    output logic [sem_pkg::COORD_W-1:0]          out_column,
    output logic [sem_pkg::ROOT_W-1:0]           magnitude,
    output logic                                 last_of_frame,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sem_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [sem_pkg::DIM_W-1:0]            cfg_data
);

    sem_pkg::sem_cmd_t    cmd;
    sem_pkg::sem_status_t status;

    // Configuration is taken in any cycle
    assign cfg_ready = 1'b1;

    sem_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sem_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .red_value     (red_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_row       (out_row),
        .out_column    (out_column),
        .magnitude     (magnitude),
        .last_of_frame (last_of_frame)
    );

    // Hold off the next beat while the accepted pixel updates the line stores
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again before line store update");

    // Only interior pixels leave the block
    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_row != '0) && (out_column != '0))
        else $error("border pixel on output");

    // Restart the frame on every write to a known register
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready
        && (cfg_index == sem_pkg::REG_IMAGE_WIDTH
         || cfg_index == sem_pkg::REG_IMAGE_HEIGHT)
        |=> status.at_origin)
        else $error("register write did not restart the frame");

    // A result is published only into a free output register
    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> !out_valid || out_ready)
        else $error("result overwrote a waiting beat");

endmodule

// ----- tb/edge_magnitude_checker.sv -----
// ============================================================================
// edge_magnitude_checker: scoreboard for the Sobel edge magnitude block
// Watches the pixel, result and register channels, keeps its own copy of the
// line stores, window and frame counters, works out the expected interior
// results and compares every result beat against them in order.
// ============================================================================
module edge_magnitude_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [sem_pkg::PIX_W-1:0]       red_value,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [sem_pkg::COORD_W-1:0]     out_row,
    input  logic [sem_pkg::COORD_W-1:0]     out_column,
    input  logic [sem_pkg::ROOT_W-1:0]      magnitude,
    input  logic                            last_of_frame,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [sem_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sem_pkg::DIM_W-1:0]       cfg_data,
    output int                              fail_count,
    output int                              pending
);

    typedef struct {
        logic [sem_pkg::COORD_W-1:0] row;
        logic [sem_pkg::COORD_W-1:0] column;
        logic [sem_pkg::ROOT_W-1:0]  magnitude;
        logic                        last;
    } edge_point_t;

    edge_point_t               expected_edges [$];
    logic [sem_pkg::PIX_W-1:0] line_two_up [sem_pkg::MAX_WIDTH];
    logic [sem_pkg::PIX_W-1:0] line_one_up [sem_pkg::MAX_WIDTH];
    logic [sem_pkg::PIX_W-1:0] far_col [3];   // column c-2: top, middle, bottom
    logic [sem_pkg::PIX_W-1:0] near_col [3];  // column c-1: top, middle, bottom
    logic [sem_pkg::DIM_W-1:0] width_raw;
    logic [sem_pkg::DIM_W-1:0] height_raw;
    int                        next_col;
    int                        next_row;

    function automatic int clamp_dim(input logic [sem_pkg::DIM_W-1:0] raw,
                                     input int ceiling);
        if (raw < sem_pkg::MIN_DIM)
        begin
            return int'(sem_pkg::MIN_DIM);
        end
        if (int'(raw) > ceiling)
        begin
            return ceiling;
        end
        return int'(raw);
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("edge check: %s", msg);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        int          i;
        int          w;
        int          h;
        int          top;
        int          mid;
        int          bot;
        int          gx;
        int          gy;
        int unsigned sq;
        int unsigned root;
        int unsigned trial;
        edge_point_t pt;

        if (!rst_n)
        begin
            for (i = 0; i < sem_pkg::MAX_WIDTH; i++)
            begin
                line_two_up[i] = '0;
                line_one_up[i] = '0;
            end
            for (i = 0; i < 3; i++)
            begin
                far_col[i]  = '0;
                near_col[i] = '0;
            end
            width_raw  = sem_pkg::RESET_WIDTH;
            height_raw = sem_pkg::RESET_HEIGHT;
            next_col   = 0;
            next_row   = 0;
            expected_edges.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // Result side first: a beat leaving now belongs to an older pixel.
            if (out_valid && out_ready)
            begin
                if (expected_edges.size() == 0)
                begin
                    note_failure($sformatf(
                        "result with nothing expected: row %0d col %0d mag %0d last %0b",
                        out_row, out_column, magnitude, last_of_frame));
                end
                else
                begin
                    pt = expected_edges.pop_front();
                    if (out_row !== pt.row || out_column !== pt.column ||
                        magnitude !== pt.magnitude || last_of_frame !== pt.last)
                    begin
                        note_failure($sformatf(
                            {"expected row %0d col %0d mag %0d last %0b, ",
                             "got row %0d col %0d mag %0d last %0b"},
                            pt.row, pt.column, pt.magnitude, pt.last,
                            out_row, out_column, magnitude, last_of_frame));
                    end
                end
            end

            // Width and height restart the frame; other indexes are ignored.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    sem_pkg::REG_IMAGE_WIDTH:
                    begin
                        width_raw = cfg_data;
                        next_col  = 0;
                        next_row  = 0;
                    end
                    sem_pkg::REG_IMAGE_HEIGHT:
                    begin
                        height_raw = cfg_data;
                        next_col   = 0;
                        next_row   = 0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (in_valid && in_ready)
            begin
                w   = clamp_dim(width_raw, sem_pkg::MAX_WIDTH);
                h   = clamp_dim(height_raw, sem_pkg::MAX_HEIGHT);
                top = line_two_up[next_col];
                mid = line_one_up[next_col];
                bot = red_value;
                if (next_row >= 2 && next_col >= 2)
                begin
                    gx = (int'(far_col[2]) + 2 * int'(near_col[2]) + bot)
                       - (int'(far_col[0]) + 2 * int'(near_col[0]) + top);
                    gy = (top + 2 * mid + bot)
                       - (int'(far_col[0]) + 2 * int'(far_col[1]) + int'(far_col[2]));
                    if (gx < 0)
                    begin
                        gx = -gx;
                    end
                    if (gy < 0)
                    begin
                        gy = -gy;
                    end
                    sq = gx * gx + gy * gy;
                    if (sq >= 32'd65536)
                    begin
                        root = 255;
                    end
                    else
                    begin
                        root = 0;
                        for (i = sem_pkg::ROOT_W - 1; i >= 0; i--)
                        begin
                            trial = root | (32'd1 << i);
                            if (trial * trial <= sq)
                            begin
                                root = trial;
                            end
                        end
                    end
                    pt.row       = sem_pkg::COORD_W'(next_row - 1);
                    pt.column    = sem_pkg::COORD_W'(next_col - 1);
                    pt.magnitude = sem_pkg::ROOT_W'(root);
                    pt.last      = (next_row == h - 1) && (next_col == w - 1);
                    expected_edges.push_back(pt);
                end

                // Shift the column into the window and the line stores.
                line_two_up[next_col] = sem_pkg::PIX_W'(mid);
                line_one_up[next_col] = sem_pkg::PIX_W'(bot);
                far_col     = near_col;
                near_col[0] = sem_pkg::PIX_W'(top);
                near_col[1] = sem_pkg::PIX_W'(mid);
                near_col[2] = sem_pkg::PIX_W'(bot);

                if (next_col + 1 >= w)
                begin
                    next_col = 0;
                    next_row = (next_row + 1 >= h) ? 0 : next_row + 1;
                end
                else
                begin
                    next_col++;
                end
            end

            pending = expected_edges.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
// ============================================================================
// tb: streaming Sobel edge magnitude testbench
// Feeds raster pixels under several frame geometries, including the clamped
// extremes, with bursty input and a stalling result sink, and lets the
// checker compare every result beat against its own prediction.
// ============================================================================
module tb;

    // Highest register index; nothing lives there.
    localparam logic [sem_pkg::CFG_INDEX_W-1:0] REG_UNUSED_TOP = '1;

    localparam int RANDOM_PIXELS   = 400;
    // Pixels for the probes of the wide frames; too few to wrap a row.
    localparam int PROBE_PIXELS    = 30;
    // Pixels for the tall narrow frame; long enough to back up under a hold-off.
    localparam int TALL_PIXELS     = 90;
    // Idle cycles after the last result; covers a full interior pixel.
    localparam int SETTLE_CYCLES   = 24;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int RUN_LIMIT       = 20_000_000;

    typedef enum int {PIX_UNIFORM, PIX_BINARY, PIX_LOW_CONTRAST} pixel_style_t;

    // Corners and steps, saturating edges and a small ramp in one 4x4 frame.
    localparam logic [sem_pkg::PIX_W-1:0] CORNER_GRID [16] = '{
        8'd0,   8'd255, 8'd0,   8'd255,
        8'd255, 8'd0,   8'd255, 8'd0,
        8'd1,   8'd2,   8'd3,   8'd4,
        8'd255, 8'd255, 8'd255, 8'd255
    };
    // Bright top row over dark rows: the gradient saturates.
    localparam logic [sem_pkg::PIX_W-1:0] RIDGE_GRID [9] = '{
        8'd255, 8'd255, 8'd255,
        8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0
    };

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic [sem_pkg::PIX_W-1:0]       red_value;
    logic                            out_valid;
    logic                            out_ready;
    logic [sem_pkg::COORD_W-1:0]     out_row;
    logic [sem_pkg::COORD_W-1:0]     out_column;
    logic [sem_pkg::ROOT_W-1:0]      magnitude;
    logic                            last_of_frame;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [sem_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [sem_pkg::DIM_W-1:0]       cfg_data;

    int fail_count;
    int pending;

    // The stimulus asks for long sink stalls; the sink counts the ones served.
    int hold_off_requests;
    int hold_offs_done;

    int                        burst_left = 1;
    int                        gap_max;
    pixel_style_t              pixel_style;
    logic [sem_pkg::PIX_W-1:0] level_base;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    sobel_edge_magnitude uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .red_value    (red_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_row      (out_row),
        .out_column   (out_column),
        .magnitude    (magnitude),
        .last_of_frame(last_of_frame),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    edge_magnitude_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .red_value    (red_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_row      (out_row),
        .out_column   (out_column),
        .magnitude    (magnitude),
        .last_of_frame(last_of_frame),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // Offer one pixel beat and hold it until taken. At the end of a burst,
    // drop valid for a random gap; otherwise keep valid high for the next beat.
    task automatic offer_pixel(input logic [sem_pkg::PIX_W-1:0] value);
        int gap;
        in_valid  <= 1'b1;
        red_value <= value;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap        = $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stream random pixels in the current style.
    task automatic stream_pixels(input int count);
        logic [sem_pkg::PIX_W-1:0] value;
        repeat (count)
        begin
            case (pixel_style)
                PIX_BINARY:       value = $urandom_range(0, 1) ? '1 : '0;
                PIX_LOW_CONTRAST: value = level_base
                                        + sem_pkg::PIX_W'($urandom_range(0, 7));
                default:          value = sem_pkg::PIX_W'($urandom);
            endcase
            offer_pixel(value);
        end
    endtask

    // Drop valid and wait until every expected result has left the block,
    // then let a pending border pixel finish before touching registers.
    task automatic settle();
        in_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        @(posedge clk);
    endtask

    // Write one register; keep valid high when another write follows.
    task automatic write_reg(input logic [sem_pkg::CFG_INDEX_W-1:0] index,
                             input logic [sem_pkg::DIM_W-1:0] data, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        if (last)
        begin
            cfg_valid <= 1'b0;
        end
    endtask

    // Result sink: stretches of always-ready, coin-flip, sparse and mostly-ready
    // patterns, with a long hold-off whenever the stimulus asks for one.
    initial
    begin : result_sink
        int stretch;
        int mode;
        int k;
        forever
        begin
            if (hold_off_requests > hold_offs_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_offs_done++;
            end
            else
            begin
                stretch = $urandom_range(10, 150);
                mode    = $urandom_range(0, 3);
                for (k = 0; k < stretch; k++)
                begin
                    case (mode)
                        0:       out_ready <= 1'b1;
                        1:       out_ready <= $urandom_range(0, 1);
                        2:       out_ready <= (k % 4 == 0);
                        default: out_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        int                              sent;
        int                              count;
        int                              i;
        logic [sem_pkg::DIM_W-1:0]       w_raw;
        logic [sem_pkg::DIM_W-1:0]       h_raw;
        logic [sem_pkg::CFG_INDEX_W-1:0] spare;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        red_value <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        pixel_style = PIX_UNIFORM;
        level_base  = '0;
        gap_max     = 12;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset geometry: the top rows of the reset frame give no results.
        stream_pixels(PROBE_PIXELS);
        settle();

        // Small frame through its end and into the next one.
        write_reg(sem_pkg::REG_IMAGE_WIDTH, 12'd4, 1'b0);
        write_reg(sem_pkg::REG_IMAGE_HEIGHT, 12'd4, 1'b1);
        foreach (CORNER_GRID[n])
        begin
            offer_pixel(CORNER_GRID[n]);
        end
        for (i = 0; i < 3; i++)
        begin
            offer_pixel(CORNER_GRID[i]);
        end
        settle();

        // Below-minimum sizes clamp to 3x3; the write restarts the frame.
        write_reg(sem_pkg::REG_IMAGE_WIDTH, 12'd0, 1'b0);
        write_reg(sem_pkg::REG_IMAGE_HEIGHT, 12'd2, 1'b1);
        for (i = 0; i < 5; i++)
        begin
            offer_pixel(RIDGE_GRID[i]);
        end
        settle();
        // An unused index mid-frame must leave the counters alone.
        write_reg(REG_UNUSED_TOP, 12'hFFF, 1'b1);
        for (i = 5; i < 9; i++)
        begin
            offer_pixel(RIDGE_GRID[i]);
        end
        settle();

        // Oversized width clamps to the full line store; no row wraps here.
        gap_max = 4;
        write_reg(sem_pkg::REG_IMAGE_WIDTH, 12'hFFF, 1'b0);
        write_reg(sem_pkg::REG_IMAGE_HEIGHT, 12'd0, 1'b1);
        stream_pixels(PROBE_PIXELS);
        settle();

        // Oversized height; stall the sink long enough to back up the input.
        hold_off_requests++;
        write_reg(sem_pkg::REG_IMAGE_WIDTH, 12'd1, 1'b0);
        write_reg(sem_pkg::REG_IMAGE_HEIGHT, 12'hFFF, 1'b1);
        stream_pixels(TALL_PIXELS);
        settle();

        // Random small geometries, partial frames and restarts.
        hold_off_requests++;
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            w_raw = ($urandom_range(0, 9) == 0)
                  ? sem_pkg::DIM_W'($urandom_range(0, 2))
                  : sem_pkg::DIM_W'($urandom_range(3, 12));
            h_raw = ($urandom_range(0, 9) == 0)
                  ? sem_pkg::DIM_W'($urandom_range(0, 2))
                  : sem_pkg::DIM_W'($urandom_range(3, 8));
            spare = sem_pkg::CFG_INDEX_W'(
                $urandom_range(int'(sem_pkg::REG_IMAGE_HEIGHT) + 1, int'(REG_UNUSED_TOP)));
            case ($urandom_range(0, 4))
                0:
                begin
                    write_reg(sem_pkg::REG_IMAGE_WIDTH, w_raw, 1'b0);
                    write_reg(sem_pkg::REG_IMAGE_HEIGHT, h_raw, 1'b1);
                end
                1:
                begin
                    write_reg(sem_pkg::REG_IMAGE_WIDTH, w_raw, 1'b1);
                end
                2:
                begin
                    write_reg(sem_pkg::REG_IMAGE_HEIGHT, h_raw, 1'b1);
                end
                3:
                begin
                    write_reg(sem_pkg::REG_IMAGE_WIDTH, w_raw, 1'b0);
                    write_reg(sem_pkg::REG_IMAGE_HEIGHT, h_raw, 1'b0);
                    write_reg(spare, sem_pkg::DIM_W'($urandom), 1'b1);
                end
                default:
                begin
                    // Continue the current frame where it stopped.
                    write_reg(spare, sem_pkg::DIM_W'($urandom), 1'b1);
                end
            endcase
            pixel_style = pixel_style_t'($urandom_range(0, 2));
            level_base  = sem_pkg::PIX_W'($urandom_range(0, 248));
            gap_max     = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 16);
            count       = $urandom_range(9, 150);
            stream_pixels(count);
            sent += count;
            settle();
        end

        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin : watchdog
        #(RUN_LIMIT);
        $display("tb: failure");
        $finish;
    end

endmodule
